// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the console writer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPW_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("console writer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPW_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("console writer assertion failed");

`endif

// ----- rtl/cpw_pkg.sv -----
// Package for the text console character writer: geometry, codes and types.
// Depends on nothing; used by cpw_sweep, the top level and the testbench.
`timescale 1ns / 1ps

package cpw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int CNT_W   = $clog2(CELLS + 1);

  // Field widths of the word ports.
  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int POS_W    = 11;
  localparam int CELL_W   = ATTR_W + CHAR_W;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  // Register file of the configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int PREG_W  = PADDR_W - 2;
  localparam logic [PREG_W-1:0] REG_BLANK_ATTR = 1'd0;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h0F;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } fsm_e;

  // Start request for a screen sweep.
  typedef struct packed {
    logic start;
    logic scroll;
  } sweep_req_t;

  // Memory port and status driven by the sweep unit.
  typedef struct packed {
    logic               active;
    logic               done;
    logic               scroll;
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [CELL_W-1:0]  wdata;
    logic [CELL_AW-1:0] raddr;
  } sweep_ctl_t;

endpackage

// ----- rtl/cpw_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module cpw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cpw_sweep.sv -----
// Screen sweep unit: scrolls the screen up one row or blanks it, one cell a cycle.
// Depends on cpw_pkg and assert_macros.svh; drives the screen RAM while active.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpw_sweep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cpw_pkg::sweep_req_t        req_i,
  input  logic [cpw_pkg::CELL_W-1:0] blank_i,
  input  logic [cpw_pkg::CELL_W-1:0] rdata_i,
  output cpw_pkg::sweep_ctl_t        ctl_o
);

  logic                      active_q, active_d;
  logic                      scroll_q, scroll_d;
  logic [cpw_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      last;
  logic                      copy;

  // The write of cell cnt-1 takes the data read from cell cnt-1+COLUMNS in the cycle before.
  assign last = (cnt_q == cpw_pkg::CNT_W'(cpw_pkg::CELLS));
  assign copy = scroll_q &&
                (cnt_q <= cpw_pkg::CNT_W'(cpw_pkg::CELLS - cpw_pkg::COLUMNS));

  // Counter and mode update.
  always_comb begin
    active_d = active_q;
    scroll_d = scroll_q;
    cnt_d    = cnt_q;
    if (req_i.start) begin
      active_d = 1'b1;
      scroll_d = req_i.scroll;
      cnt_d    = '0;
    end else if (active_q) begin
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      scroll_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      scroll_q <= scroll_d;
      cnt_q    <= cnt_d;
    end
  end

  // Memory port: copy rows up while scrolling, blank fill otherwise.
  always_comb begin
    ctl_o.active = active_q;
    ctl_o.done   = active_q && last;
    ctl_o.scroll = scroll_q;
    ctl_o.we     = active_q && (cnt_q != '0);
    ctl_o.waddr  = cpw_pkg::CELL_AW'(cnt_q - 1'b1);
    ctl_o.wdata  = copy ? rdata_i : blank_i;
    ctl_o.raddr  = cpw_pkg::CELL_AW'(cnt_q + cpw_pkg::CNT_W'(cpw_pkg::COLUMNS));
  end

  // A new sweep starts only while the unit is free.
  `CPW_ASSERT_IMP(a_start_idle, clk_i, rst_ni, req_i.start, !active_q)
  // The counter steps by one each cycle of a sweep.
  `CPW_ASSERT_NXT(a_cnt_step, clk_i, rst_ni, active_q && !last && !req_i.start,
                  cnt_q == $past(cnt_q) + 1'b1)
  // While rows are copied, the cell read is never the cell being written.
  `CPW_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, active_q && copy,
                  ctl_o.raddr != ctl_o.waddr)

endmodule

// ----- rtl/text_console_char_writer_top.sv -----
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_stall_o      opcode, char_code, attribute, cell_index
// out       output     out_valid_o / out_stall_i    cursor_position, cell_data, scrolled
// cfg       input      psel, penable, pwrite        paddr, pwdata, prdata, pready
//
// A put that does not scroll, or an unused opcode, gives its result word in the cycle after
// acceptance; a read first waits in the READ state for the registered RAM read port.
// A scroll or clear sweeps the single-write-port screen RAM, one cell per cycle,
// with the input stalled throughout.
// Reset clears the cursor and control; screen cells are undefined until cleared.
// A stalled result holds the input stalled too; the next word is taken as it leaves.
//
// Top level of the text console character writer.
// Depends on cpw_pkg, cpw_ram, cpw_sweep and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_char_writer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cpw_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [cpw_pkg::CHAR_W-1:0]          char_code_i,
  input  logic [cpw_pkg::ATTR_W-1:0]          attribute_i,
  input  logic [cpw_pkg::INDEX_W-1:0]         cell_index_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cpw_pkg::POS_W-1:0]           cursor_position_o,
  output logic [cpw_pkg::CELL_W-1:0]          cell_data_o,
  output logic                                scrolled_o,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cpw_pkg::PADDR_W-1:0]         paddr,
  input  logic [cpw_pkg::PDATA_W-1:0]         pwdata,
  output logic [cpw_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  cpw_pkg::fsm_e                      state_q, state_d;
  logic [cpw_pkg::COL_W-1:0]          col_q, col_d;
  logic [cpw_pkg::ROW_W-1:0]          row_q, row_d;
  logic [cpw_pkg::ATTR_W-1:0]         blank_attr_q;
  logic                               out_valid_q;
  logic [cpw_pkg::CELL_W-1:0]         cell_data_q, cell_data_d;
  logic                               scrolled_q, scrolled_d;
  logic                               rd_oob_q;
  logic                               out_load;
  logic                               in_accept;
  logic                               out_taken;
  logic                               cfg_write;
  logic [cpw_pkg::PREG_W-1:0]         reg_sel;
  logic [cpw_pkg::CELL_W-1:0]         blank_cell;
  logic                               is_lf, is_cr;
  logic [cpw_pkg::COL_W:0]            col_inc, next_col;
  logic [cpw_pkg::ROW_W:0]            row_inc, next_row;
  logic                               put_scroll;
  logic [cpw_pkg::CELL_AW-1:0]        cursor_addr;
  cpw_pkg::sweep_req_t                sweep_req;
  cpw_pkg::sweep_ctl_t                sweep_ctl;
  logic                               mem_we;
  logic [cpw_pkg::CELL_AW-1:0]        mem_waddr, mem_raddr;
  logic [cpw_pkg::CELL_W-1:0]         mem_wdata, mem_rdata;

  // Linear cell address of a row and column.
  function automatic logic [cpw_pkg::CELL_AW-1:0] cell_addr(
    input logic [cpw_pkg::ROW_W-1:0] row,
    input logic [cpw_pkg::COL_W-1:0] col
  );
    logic [cpw_pkg::CELL_AW-1:0] base;
    base = cpw_pkg::CELL_AW'(row) * cpw_pkg::CELL_AW'(cpw_pkg::COLUMNS);
    return base + cpw_pkg::CELL_AW'(col);
  endfunction

  // Handshakes.
  assign in_stall_o = (state_q != cpw_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_taken  = out_valid_q && !out_stall_i;

  // Configuration register.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[cpw_pkg::PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready &&
                     (reg_sel == cpw_pkg::REG_BLANK_ATTR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_attr_q <= cpw_pkg::BLANK_ATTR_RESET;
    end else if (cfg_write) begin
      blank_attr_q <= pwdata[cpw_pkg::ATTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == cpw_pkg::REG_BLANK_ATTR) begin
      prdata = cpw_pkg::PDATA_W'(blank_attr_q);
    end
  end

  assign blank_cell = {blank_attr_q, cpw_pkg::CHAR_SPACE};

  // Cursor advance for a put: line feed, carriage return, or a printed cell.
  assign is_lf       = (char_code_i == cpw_pkg::CHAR_LF);
  assign is_cr       = (char_code_i == cpw_pkg::CHAR_CR);
  assign col_inc     = {1'b0, col_q} + 1'b1;
  assign row_inc     = {1'b0, row_q} + 1'b1;
  assign cursor_addr = cell_addr(row_q, col_q);

  always_comb begin
    next_col = col_inc;
    next_row = {1'b0, row_q};
    if (is_lf) begin
      next_col = '0;
      next_row = row_inc;
    end else if (is_cr) begin
      next_col = '0;
    end else if (col_inc == (cpw_pkg::COL_W + 1)'(cpw_pkg::COLUMNS)) begin
      next_col = '0;
      next_row = row_inc;
    end
  end

  assign put_scroll = (next_row == (cpw_pkg::ROW_W + 1)'(cpw_pkg::ROWS));

  // Next state of the control sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpw_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (opcode_i == cpw_pkg::OP_READ) begin
            state_d = cpw_pkg::ST_READ;
          end else if ((opcode_i == cpw_pkg::OP_CLEAR) ||
                       ((opcode_i == cpw_pkg::OP_PUT) && put_scroll)) begin
            state_d = cpw_pkg::ST_SWEEP;
          end
        end
      end
      cpw_pkg::ST_READ: begin
        state_d = cpw_pkg::ST_IDLE;
      end
      cpw_pkg::ST_SWEEP: begin
        if (sweep_ctl.done) begin
          state_d = cpw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpw_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: memory requests, cursor update and result loading.
  always_comb begin
    col_d            = col_q;
    row_d            = row_q;
    out_load         = 1'b0;
    cell_data_d      = '0;
    scrolled_d       = 1'b0;
    sweep_req.start  = 1'b0;
    sweep_req.scroll = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = cursor_addr;
    mem_wdata        = {attribute_i, char_code_i};
    mem_raddr        = cpw_pkg::CELL_AW'(cell_index_i);
    case (state_q)
      cpw_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (opcode_i)
            cpw_pkg::OP_PUT: begin
              mem_we = !is_lf && !is_cr;
              col_d  = cpw_pkg::COL_W'(next_col);
              if (put_scroll) begin
                row_d            = cpw_pkg::ROW_W'(cpw_pkg::ROWS - 1);
                sweep_req.start  = 1'b1;
                sweep_req.scroll = 1'b1;
              end else begin
                row_d    = cpw_pkg::ROW_W'(next_row);
                out_load = 1'b1;
              end
            end
            cpw_pkg::OP_READ: begin
              out_load = 1'b0;
            end
            cpw_pkg::OP_CLEAR: begin
              col_d           = '0;
              row_d           = '0;
              sweep_req.start = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      cpw_pkg::ST_READ: begin
        out_load    = 1'b1;
        cell_data_d = rd_oob_q ? '0 : mem_rdata;
      end
      cpw_pkg::ST_SWEEP: begin
        mem_we     = sweep_ctl.we;
        mem_waddr  = sweep_ctl.waddr;
        mem_wdata  = sweep_ctl.wdata;
        mem_raddr  = sweep_ctl.raddr;
        out_load   = sweep_ctl.done;
        scrolled_d = sweep_ctl.scroll;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers and cursor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpw_pkg::ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload and read range flag.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cell_data_q <= cell_data_d;
      scrolled_q  <= scrolled_d;
    end
    if (in_accept) begin
      rd_oob_q <= (32'(cell_index_i) >= 32'(cpw_pkg::CELLS));
    end
  end

  // The cursor changes only when a word is accepted, so it stays put under stall.
  assign out_valid_o       = out_valid_q;
  assign cell_data_o       = cell_data_q;
  assign scrolled_o        = scrolled_q;
  assign cursor_position_o = cpw_pkg::POS_W'(cursor_addr);

  // Screen memory.
  cpw_ram #(
    .WIDTH(cpw_pkg::CELL_W),
    .DEPTH(cpw_pkg::CELLS)
  ) u_screen_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Scroll and clear sweeps.
  cpw_sweep u_sweep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sweep_req),
    .blank_i(blank_cell),
    .rdata_i(mem_rdata),
    .ctl_o  (sweep_ctl)
  );

  // The result register is empty whenever a read or sweep is in flight.
  `CPW_ASSERT_IMP(a_out_empty_busy, clk_i, rst_ni, state_q != cpw_pkg::ST_IDLE,
                  !out_valid_q)
  // The cursor always stays on the screen.
  `CPW_ASSERT_IMP(a_cursor_range, clk_i, rst_ni, 1'b1,
                  (col_q < cpw_pkg::COLUMNS) && (row_q < cpw_pkg::ROWS))
  // A clear homes the cursor and starts a sweep.
  `CPW_ASSERT_NXT(a_clear_home, clk_i, rst_ni,
                  in_accept && (opcode_i == cpw_pkg::OP_CLEAR),
                  (col_q == '0) && (row_q == '0) && sweep_ctl.active)
  // The sweep unit is busy exactly while the sequencer waits on it.
  `CPW_ASSERT_IMP(a_sweep_sync, clk_i, rst_ni, 1'b1,
                  sweep_ctl.active == (state_q == cpw_pkg::ST_SWEEP))

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the text console character writer.
// Depends on cpw_pkg and text_console_char_writer_top; it keeps its own screen model.
`timescale 1ns / 1ps

module testbench;
  import cpw_pkg::*;

  localparam int CYCLE_LIMIT     = 20_000_000;
  localparam int WORDS_PER_PHASE = 220;
  localparam int PRINT_LIMIT     = 100;
  localparam logic [OPCODE_W-1:0] OP_UNUSED    = 2'd3;
  localparam logic [PREG_W-1:0]   REG_UNMAPPED = 1'd1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [ATTR_W-1:0]   attribute;
    logic [INDEX_W-1:0]  cell_index;
  } console_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } console_result_t;

  // Stimulus and response signals of the block.
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [OPCODE_W-1:0] opcode_i     = '0;
  logic [CHAR_W-1:0]   char_code_i  = '0;
  logic [ATTR_W-1:0]   attribute_i  = '0;
  logic [INDEX_W-1:0]  cell_index_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [POS_W-1:0]    cursor_position_o;
  logic [CELL_W-1:0]   cell_data_o;
  logic                scrolled_o;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PADDR_W-1:0]  paddr        = '0;
  logic [PDATA_W-1:0]  pwdata       = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Screen model, cursor and register copy.
  logic [CELL_W-1:0] screen_model [CELLS];
  int                cur_col;
  int                cur_row;
  logic [ATTR_W-1:0] blank_attr_model;

  console_result_t expected_results [$];
  console_result_t oldest_result;

  int send_idle_pct   = 0;
  int out_stall_pct   = 0;
  int mismatches      = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int scrolls_seen    = 0;
  int clears_seen     = 0;
  int cycle_count     = 0;

  text_console_char_writer_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .char_code_i       (char_code_i),
    .attribute_i       (attribute_i),
    .cell_index_i      (cell_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_position_o (cursor_position_o),
    .cell_data_o       (cell_data_o),
    .scrolled_o        (scrolled_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Clock with a 2 ns period.
  always #1 clk_i = ~clk_i;

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Counts a mismatch and prints its line; beyond PRINT_LIMIT mismatches they are counted only.
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH %s: got 0x%0h, want 0x%0h (result %0d)", what, got, want,
               results_checked);
  endtask

  // Applies one word to the screen model and returns the result it should give.
  function automatic console_result_t apply_console_cmd(input console_cmd_t cmd);
    console_result_t res;
    int i;
    res = '0;
    case (cmd.opcode)
      OP_PUT: begin
        if (cmd.char_code == CHAR_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (cmd.char_code == CHAR_CR) begin
          cur_col = 0;
        end else begin
          screen_model[cur_row * COLUMNS + cur_col] = {cmd.attribute, cmd.char_code};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // Moving below the last row shifts the screen up and blanks the bottom row.
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = {blank_attr_model, CHAR_SPACE};
          cur_row      = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      OP_READ: begin
        if (cmd.cell_index < CELLS) res.cell_data = screen_model[cmd.cell_index];
      end
      OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_model[i] = {blank_attr_model, CHAR_SPACE};
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
      end
    endcase
    res.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  // Sends one word; called just after a falling edge and returns at one.
  task automatic send_word(input int op, input int ch, input int attr, input int idx);
    console_cmd_t    cmd;
    console_result_t res;
    cmd = {OPCODE_W'(op), CHAR_W'(ch), ATTR_W'(attr), INDEX_W'(idx)};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= cmd.opcode;
    char_code_i  <= cmd.char_code;
    attribute_i  <= cmd.attribute;
    cell_index_i <= cmd.cell_index;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = apply_console_cmd(cmd);
    expected_results.push_back(res);
    words_sent++;
    if (res.scrolled) scrolls_seen++;
    if (cmd.opcode == OP_CLEAR) clears_seen++;
    @(negedge clk_i);
  endtask

  // Result checker: each accepted word is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", cursor_position_o, 0);
      end else begin
        oldest_result = expected_results.pop_front();
        if (cursor_position_o !== oldest_result.cursor_position)
          report_mismatch("cursor_position", cursor_position_o, oldest_result.cursor_position);
        if (cell_data_o !== oldest_result.cell_data)
          report_mismatch("cell_data", cell_data_o, oldest_result.cell_data);
        if (scrolled_o !== oldest_result.scrolled)
          report_mismatch("scrolled", scrolled_o, oldest_result.scrolled);
      end
      results_checked++;
    end
  end

  // Lets every outstanding result drain, then waits with the block idle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [PREG_W-1:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_BLANK_ATTR) blank_attr_model = value[ATTR_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Register read, checked against the model's copy of the blank attribute.
  task automatic check_blank_reg();
    logic [PDATA_W-1:0] value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_BLANK_ATTR, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    value = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    if (value[ATTR_W-1:0] !== blank_attr_model)
      report_mismatch("blank_attribute readback", value[ATTR_W-1:0], blank_attr_model);
  endtask

  // Reset value of the register, first clear, out-of-range read and the unused opcode.
  task automatic test_reset_state();
    check_blank_reg();
    send_word(OP_CLEAR, 8'h00, 8'h00, 0);
    send_word(OP_READ, 8'h00, 8'h00, 0);
    send_word(OP_READ, 8'hFF, 8'hFF, CELLS - 1);
    send_word(OP_READ, 8'h00, 8'h00, 2047);
    send_word(OP_UNUSED, 8'hFF, 8'hFF, 2047);
  endtask

  // Field extremes on put, carriage return and line feed, and read-back.
  task automatic test_put_and_read();
    send_word(OP_PUT, 8'h00, 8'h00, 2047);
    send_word(OP_PUT, 8'hFF, 8'hFF, 0);
    send_word(OP_PUT, 8'h41, 8'h1E, 0);
    send_word(OP_PUT, CHAR_CR, 8'h00, 0);
    send_word(OP_PUT, 8'h42, 8'h70, 0);
    send_word(OP_PUT, CHAR_LF, 8'h00, 0);
    send_word(OP_PUT, 8'h43, 8'h0E, 0);
    send_word(OP_READ, 8'h00, 8'h00, 0);
    send_word(OP_READ, 8'h00, 8'h00, 1);
    send_word(OP_READ, 8'h00, 8'h00, 2);
    send_word(OP_READ, 8'h00, 8'h00, COLUMNS);
  endtask

  // Blank attribute at both extremes, a write to an unmapped register, and a clear.
  task automatic test_config_port();
    wait_drained();
    write_reg(REG_BLANK_ATTR, 32'h0000_00FF);
    write_reg(REG_UNMAPPED, 32'hFFFF_FF00);
    check_blank_reg();
    send_word(OP_CLEAR, 8'h00, 8'h00, 0);
    send_word(OP_READ, 8'h00, 8'h00, CELLS - 1);
    wait_drained();
    write_reg(REG_BLANK_ATTR, 32'h0000_0000);
    check_blank_reg();
  endtask

  // Line feeds walk the cursor to the bottom until the screen scrolls.
  task automatic test_line_feed_scroll();
    send_word(OP_PUT, 8'h5A, 8'h4F, 0);
    repeat (ROWS) send_word(OP_PUT, CHAR_LF, 8'h00, 0);
    send_word(OP_READ, 8'h00, 8'h00, 0);
    send_word(OP_READ, 8'h00, 8'h00, CELLS - 1);
  endtask

  // Random traffic: mostly lines of text, with reads, clears, line-feed bursts and noise.
  task automatic test_random_traffic(input int in_idle, input int out_stall,
                                     input logic [ATTR_W-1:0] blank);
    int start;
    int kind;
    int len;
    wait_drained();
    write_reg(REG_BLANK_ATTR, {{(PDATA_W - ATTR_W){1'b0}}, blank});
    send_idle_pct = in_idle;
    out_stall_pct = out_stall;
    start = words_sent;
    while (words_sent - start < WORDS_PER_PHASE) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        // A line of text; now and then long enough to wrap past the row end.
        len = ($urandom_range(7) == 0) ? $urandom_range(170, 60) : $urandom_range(24);
        repeat (len)
          send_word(OP_PUT, $urandom_range(255), $urandom_range(255), $urandom_range(2047));
        if ($urandom_range(3) != 0)
          send_word(OP_PUT, CHAR_CR, $urandom_range(255), $urandom_range(2047));
        send_word(OP_PUT, CHAR_LF, $urandom_range(255), $urandom_range(2047));
      end else if (kind < 80) begin
        // A few reads, some beyond the screen.
        repeat ($urandom_range(4, 1))
          send_word(OP_READ, $urandom_range(255), $urandom_range(255),
                    ($urandom_range(9) == 0) ? $urandom_range(2047, CELLS)
                                             : $urandom_range(CELLS - 1));
      end else if (kind < 90) begin
        // Noise: any opcode with any fields.
        send_word($urandom_range(3), $urandom_range(255), $urandom_range(255),
                  $urandom_range(2047));
      end else if (kind < 92) begin
        send_word(OP_CLEAR, $urandom_range(255), $urandom_range(255), $urandom_range(2047));
      end else begin
        // A burst of line feeds, which scrolls once the cursor is at the bottom.
        repeat ($urandom_range(6, 1))
          send_word(OP_PUT, CHAR_LF, $urandom_range(255), $urandom_range(2047));
      end
    end
  endtask

  // Test sequence.
  initial begin
    cur_col          = 0;
    cur_row          = 0;
    blank_attr_model = BLANK_ATTR_RESET;
    foreach (screen_model[i]) screen_model[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // The screen is cleared first, so no read ever sees an unwritten cell.
    test_reset_state();
    test_put_and_read();
    test_config_port();
    test_line_feed_scroll();

    test_random_traffic(0, 0, 8'h00);
    test_random_traffic(83, 0, 8'hFF);
    test_random_traffic(0, 83, ATTR_W'($urandom_range(255)));
    test_random_traffic(26, 26, BLANK_ATTR_RESET);

    wait_drained();
    send_idle_pct = 0;
    out_stall_pct = 0;
    repeat (16) @(negedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);

    $display("Sent %0d words including %0d clears and %0d scrolls; checked %0d results.",
             words_sent, clears_seen, scrolls_seen, results_checked);
    $display("Idling covered free flow, sparse sender, heavy receiver stall and mixed gaps.");
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cpw_pkg.sv
rtl/cpw_ram.sv
rtl/cpw_sweep.sv
rtl/text_console_char_writer_top.sv
tb/testbench.sv
